// ===== rtl/core/fde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Finite difference extrapolator package
// Shared widths and the result record handed from the engine to the top level.
// ----------------------------------------------------------------------------

package fde_pkg;

	localparam int SAMPLE_W = 32;
	localparam int VALUE_W  = 64;

	typedef logic [VALUE_W-1:0] value_t;

	// One finished sequence: both extrapolations and the capacity flag.
	typedef struct packed {
		logic   too_long;
		value_t previous_value;
		value_t next_value;
	} result_t;

endpackage

// ===== rtl/core/finite_difference_extrapolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Finite difference extrapolator
// Difference engine over one sequence at a time; on the last sample it returns
// the forward and backward polynomial extrapolations.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Contents
// s_*      in         sample_value in tdata, last_sample in tlast
// m_*      out        next_value, previous_value in tdata; too_long in tuser
//
// A sample that finds c levels stored rewrites them and adds one, bound by the single
// port of the level memory, which is visited once per level.
// A sample past capacity is dropped without a walk; a closing sample passes through
// ST_EMIT to hand its result to the output register.
// Reset empties the sequence; the level memory needs no clearing pass.
// The result waits in the output register while new samples are taken; the
// engine stalls only when a second result meets a full output register.
// ----------------------------------------------------------------------------

module finite_difference_extrapolator #(
	parameter int MAX_LEVELS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // [31:0] sample_value
	input  logic         s_tlast,   // last_sample
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // [63:0] next_value, [127:64] previous_value
	output logic         m_tuser    // too_long
);

	localparam int AW = $clog2(MAX_LEVELS);

	logic             mem_we;
	logic [AW-1:0]    mem_addr;
	fde_pkg::value_t  mem_wdata;
	fde_pkg::value_t  mem_rdata;
	logic             res_valid;
	logic             res_ready;
	fde_pkg::result_t res;
	fde_pkg::result_t out_q;
	logic             out_valid_q;

	fde_level_mem #(
		.DEPTH (MAX_LEVELS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	fde_engine #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sample (s_tdata),
		.in_last   (s_tlast),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.previous_value, out_q.next_value};
	assign m_tuser  = out_q.too_long;

endmodule

// ===== rtl/core/fde_level_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Difference level memory
// Single-port synchronous RAM holding the newest value of every difference
// level. Read data is registered and returns the old contents on a same-address
// write.
// ----------------------------------------------------------------------------

module fde_level_mem #(
	parameter  int DEPTH = 32,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         addr,
	input  fde_pkg::value_t       wdata,
	output fde_pkg::value_t       rdata
);

	fde_pkg::value_t mem [DEPTH];
	fde_pkg::value_t rdata_q;

	always_ff @(posedge clk) begin
		rdata_q <= mem[addr];
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/fde_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Difference engine sequencer
// Walks the stored levels once per sample, one level a cycle, writing the new
// value of each level and carrying the difference down. Keeps the forward and
// backward sums and hands one result per sequence.
// ----------------------------------------------------------------------------

module fde_engine #(
	parameter  int MAX_LEVELS = 32,
	localparam int AW         = $clog2(MAX_LEVELS),
	localparam int CW         = $clog2(MAX_LEVELS + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [fde_pkg::SAMPLE_W-1:0] in_sample,
	input  logic                              in_last,
	output logic                              mem_we,
	output logic [AW-1:0]                     mem_addr,
	output fde_pkg::value_t                   mem_wdata,
	input  fde_pkg::value_t                   mem_rdata,
	output logic                              res_valid,
	input  logic                              res_ready,
	output fde_pkg::result_t                  res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_SUM,
		ST_EMIT
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   step_q;
	logic [CW-1:0]   count_q;
	fde_pkg::value_t cur_q;
	fde_pkg::value_t fsum_q;
	fde_pkg::value_t bsum_q;
	logic            ovf_q;
	logic            last_q;

	fde_pkg::value_t val;
	logic            step_end;
	logic            full;

	// Level 0 takes the sample itself; deeper levels take the running difference.
	assign val      = (step_q == '0) ? cur_q : cur_q - mem_rdata;
	assign step_end = (CW'(step_q) == count_q);
	assign full     = (count_q == CW'(MAX_LEVELS));

	assign in_ready  = (state_q == ST_IDLE);
	assign mem_we    = (state_q == ST_RUN);
	assign mem_addr  = step_q;
	assign mem_wdata = val;
	assign res_valid = (state_q == ST_EMIT);
	assign res       = '{too_long: ovf_q, previous_value: bsum_q, next_value: fsum_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			count_q <= '0;
			cur_q   <= '0;
			fsum_q  <= '0;
			bsum_q  <= '0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						last_q <= in_last;
						if (full) begin
							// Past capacity: the value is dropped but the flag still closes.
							ovf_q <= 1'b1;
							if (in_last) begin
								state_q <= ST_EMIT;
							end
						end else begin
							cur_q   <= {{(fde_pkg::VALUE_W - fde_pkg::SAMPLE_W){in_sample[fde_pkg::SAMPLE_W-1]}},
								in_sample};
							step_q  <= '0;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					cur_q <= val;
					// The sum trails the walk by one level to keep one adder per path.
					if (step_q == '0) begin
						fsum_q <= '0;
					end else begin
						fsum_q <= fsum_q + cur_q;
					end
					if (step_end) begin
						state_q <= ST_SUM;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SUM: begin
					fsum_q  <= fsum_q + cur_q;
					bsum_q  <= count_q[0] ? bsum_q - cur_q : bsum_q + cur_q;
					count_q <= count_q + 1'b1;
					state_q <= last_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (res_ready) begin
						count_q <= '0;
						fsum_q  <= '0;
						bsum_q  <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_LEVELS))
		else $error("level count beyond capacity");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (CW'(step_q) <= count_q))
		else $error("level walk past the newest level");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> full)
		else $error("overflow flagged while capacity remains");

	a_sum_then_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |=> (count_q == $past(count_q) + 1'b1))
		else $error("level count not advanced after a sample");

endmodule
